[sv/spherical_to_cartesian_point_assert.svh]
// Assertion macros for the spherical-to-Cartesian converter.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef SPHERICAL_TO_CARTESIAN_POINT_ASSERT_SVH
`define SPHERICAL_TO_CARTESIAN_POINT_ASSERT_SVH

// same-cycle implication
`define STCP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/stcp_pkg.sv]
// Shared constants and types for the spherical-to-Cartesian converter.
// No dependencies.
`default_nettype none
package stcp_pkg;

  typedef logic signed [31:0] trig_t;

  localparam int ATAN_ENTRIES = 24;
  localparam trig_t CORDIC_X0 = 32'sh26DD3B6A; // 1/K in Q1.30
  localparam trig_t TRIG_ONE  = 32'sh40000000;

  // atan(2^-i) in 2^-32 turn units
  localparam trig_t ATAN_TURNS [ATAN_ENTRIES] = '{
    32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
    32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
    32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051
  };

endpackage
`default_nettype wire

[sv/spherical_to_cartesian_point.sv]
// Spherical-to-Cartesian point converter, top level.
// Depends on stcp_pkg, stcp_cordic, stcp_mul_q30, stcp_delay and the assert header.
`default_nettype none
`include "spherical_to_cartesian_point_assert.svh"
// One point per request: radius r (unsigned, 16 fraction bits), azimuth theta
// and polar angle phi (binary angles, 2^ANGLE_BITS counts per turn). Gives
// x = r sin(phi) cos(theta), y = r sin(phi) sin(theta), z = r cos(phi), each
// signed, RADIUS_BITS+1 bits, same scale as r, truncated toward zero; tlast
// passes through. Fully pipelined: one point per clock (two CORDICs in
// parallel, then two chained Q1.30 multiplies). The whole pipe advances on
// one enable; it freezes only while the output holds a result that is not taken.
module spherical_to_cartesian_point #(
  parameter int RADIUS_BITS = 32,
  parameter int ANGLE_BITS  = 16,
  parameter int TRIG_STAGES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [radius | azimuth | polar | zero pad], lowest bits first
  input  wire logic [((RADIUS_BITS+2*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  wire logic              s_axis_tlast_i,   // last_point
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // [coord_x | coord_y | coord_z | zero pad], lowest bits first
  output logic [((3*(RADIUS_BITS+1)+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o    // last_out
);
  import stcp_pkg::*;

  localparam int OW     = RADIUS_BITS + 1;
  localparam int OUT_TW = ((3*OW+7)/8)*8;
  localparam int CLAT   = TRIG_STAGES + 2;
  localparam int LAT    = CLAT + 4;
  localparam logic [OW-1:0] MOST_NEG = {1'b1, {RADIUS_BITS{1'b0}}};

  logic                   adv;
  logic [LAT-1:0]         vld_q;
  logic [RADIUS_BITS-1:0] radius;
  logic [ANGLE_BITS-1:0]  azimuth, polar;
  logic [RADIUS_BITS-1:0] radius_dly;
  trig_t                  sin_t, cos_t, sin_p, cos_p, sin_t_dly, cos_t_dly;
  logic signed [OW-1:0]   rs, z_a, z_b, coord_x, coord_y;

  assign radius  = s_axis_tdata_i[RADIUS_BITS-1:0];
  assign azimuth = s_axis_tdata_i[RADIUS_BITS +: ANGLE_BITS];
  assign polar   = s_axis_tdata_i[RADIUS_BITS+ANGLE_BITS +: ANGLE_BITS];

  // the pipe moves whenever the output slot is free or being drained
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end
  assign m_axis_tvalid_o = vld_q[LAT-1];

  stcp_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(TRIG_STAGES)) u_trig_theta (
    .clk_i, .en_i(adv), .angle_i(azimuth), .sin_o(sin_t), .cos_o(cos_t)
  );
  stcp_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(TRIG_STAGES)) u_trig_phi (
    .clk_i, .en_i(adv), .angle_i(polar), .sin_o(sin_p), .cos_o(cos_p)
  );

  // radius waits out the CORDIC latency
  stcp_delay #(.W(RADIUS_BITS), .D(CLAT)) u_dly_radius (
    .clk_i, .en_i(adv), .d_i(radius), .q_o(radius_dly)
  );

  // first multiply: r sin(phi) and r cos(phi)
  stcp_mul_q30 #(.VW(OW)) u_mul_rs (
    .clk_i, .en_i(adv), .v_i($signed({1'b0, radius_dly})), .f_i(sin_p), .p_o(rs)
  );
  stcp_mul_q30 #(.VW(OW)) u_mul_z (
    .clk_i, .en_i(adv), .v_i($signed({1'b0, radius_dly})), .f_i(cos_p), .p_o(z_a)
  );

  // theta terms and z wait out one multiply each
  stcp_delay #(.W(64), .D(2)) u_dly_theta (
    .clk_i, .en_i(adv), .d_i({sin_t, cos_t}), .q_o({sin_t_dly, cos_t_dly})
  );
  stcp_delay #(.W(OW), .D(2)) u_dly_z (
    .clk_i, .en_i(adv), .d_i(z_a), .q_o(z_b)
  );

  // second multiply: rs cos(theta), rs sin(theta); its register is the output
  stcp_mul_q30 #(.VW(OW)) u_mul_x (
    .clk_i, .en_i(adv), .v_i(rs), .f_i(cos_t_dly), .p_o(coord_x)
  );
  stcp_mul_q30 #(.VW(OW)) u_mul_y (
    .clk_i, .en_i(adv), .v_i(rs), .f_i(sin_t_dly), .p_o(coord_y)
  );

  stcp_delay #(.W(1), .D(LAT)) u_dly_last (
    .clk_i, .en_i(adv), .d_i(s_axis_tlast_i), .q_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_TW'({z_b, coord_y, coord_x});

  // magnitudes never exceed r, so the most negative code cannot appear
  `STCP_ASSERT_IMPL(a_x_range, m_axis_tvalid_o, coord_x != MOST_NEG, "coord_x out of range")
  `STCP_ASSERT_IMPL(a_z_range, m_axis_tvalid_o, z_b != MOST_NEG, "coord_z out of range")
  // an accepted request must enter the first valid stage
  `STCP_ASSERT_NEXT(a_enter, s_axis_tvalid_i && s_axis_tready_o, vld_q[0], "request lost")
  // a held result freezes the whole pipe
  `STCP_ASSERT_NEXT(a_freeze, m_axis_tvalid_o && !m_axis_tready_i, $stable(vld_q),
                    "pipe moved while stalled")

endmodule
`default_nettype wire

[sv/stcp_delay.sv]
// Enabled payload delay line of fixed depth.
// No dependencies.
`default_nettype none
module stcp_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);
  logic [W-1:0] tap_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < D; k++) tap_q[k] <= tap_q[k-1];
    end
  end

  assign q_o = tap_q[D-1];
endmodule
`default_nettype wire

[sv/stcp_cordic.sv]
// Pipelined rotation CORDIC: sine and cosine of a binary angle, Q1.30.
// Depends on stcp_pkg; input and output are registered.
`default_nettype none
module stcp_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int STAGES     = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [ANGLE_BITS-1:0] angle_i,
  output stcp_pkg::trig_t            sin_o,
  output stcp_pkg::trig_t            cos_o
);
  import stcp_pkg::*;

  trig_t x_q [STAGES+1];
  trig_t y_q [STAGES+1];
  trig_t z_q [STAGES+1];
  logic  flip_q [STAGES+1];

  logic [31:0] turn;
  logic        flip;

  // fold quadrants 2 and 3 onto 4 and 1; negate at the end
  always_comb begin
    turn = 32'(angle_i) << (32 - ANGLE_BITS);
    flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    if (flip) turn = turn ^ 32'h8000_0000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_X0;
      y_q[0]    <= '0;
      z_q[0]    <= trig_t'(turn);
      flip_q[0] <= flip;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_TURNS[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_TURNS[i];
        end
      end
    end
  end

  trig_t cos_d, sin_d;

  always_comb begin
    cos_d = flip_q[STAGES] ? -x_q[STAGES] : x_q[STAGES];
    sin_d = flip_q[STAGES] ? -y_q[STAGES] : y_q[STAGES];
    if (cos_d > TRIG_ONE)  cos_d = TRIG_ONE;
    if (cos_d < -TRIG_ONE) cos_d = -TRIG_ONE;
    if (sin_d > TRIG_ONE)  sin_d = TRIG_ONE;
    if (sin_d < -TRIG_ONE) sin_d = -TRIG_ONE;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_d;
      sin_o <= sin_d;
    end
  end
endmodule
`default_nettype wire

[sv/stcp_mul_q30.sv]
// Two-stage signed scale by a Q1.30 factor, truncating toward zero.
// Depends on stcp_pkg. Magnitude product split at bit 24 of the value.
`default_nettype none
module stcp_mul_q30 #(
  parameter int VW = 33
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [VW-1:0] v_i,
  input  wire stcp_pkg::trig_t      f_i,
  output logic signed [VW-1:0]      p_o
);
  import stcp_pkg::*;

  localparam int AW = VW - 1;
  localparam int PW = (AW > 24) ? AW : 25;
  localparam int HW = PW - 24;
  localparam int QW = HW + 32;

  logic [VW-1:0]   mag_v_full;
  logic [PW-1:0]   mag_v;
  logic [31:0]     mag_f_full;
  logic [30:0]     mag_f;
  logic [HW+30:0]  hi_prod_q;
  logic [54:0]     lo_prod_q;
  logic            neg_q;
  logic [QW-1:0]   q_sum;
  logic [AW-1:0]   mag;

  always_comb begin
    mag_v_full = v_i[VW-1] ? VW'(-v_i) : VW'(v_i);
    mag_v      = PW'(mag_v_full[AW-1:0]);
    mag_f_full = f_i[31] ? 32'(-f_i) : 32'(f_i);
    mag_f      = mag_f_full[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_prod_q <= (HW+31)'(mag_v[PW-1:24]) * (HW+31)'(mag_f);
      lo_prod_q <= 55'(mag_v[23:0]) * 55'(mag_f);
      neg_q     <= v_i[VW-1] ^ f_i[31];
    end
  end

  always_comb begin
    q_sum = QW'(hi_prod_q) + QW'(lo_prod_q[54:24]);
    mag   = q_sum[AW+5:6];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p_o <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end
endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for spherical_to_cartesian_point: random and directed points,
// result check against a bit-exact CORDIC and Q1.30 product predictor.
// Depends on stcp_pkg and the RTL of the converter.
`timescale 1ns / 1ps

class point_scoreboard;
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               last;
  } coord_t;

  coord_t      pending_q[$];
  int unsigned mismatch_cnt;

  // floor shift of a signed value, as the CORDIC datapath does it
  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function void trig(logic [15:0] ang, output longint s, output longint c);
    logic [31:0] t;
    logic [1:0]  quad;
    bit          flip;
    longint      xv, yv, zv, nx, ny;
    t    = {ang, 16'h0};
    quad = t[31:30];
    flip = (quad == 2'd1) || (quad == 2'd2);
    if (flip) t = t + 32'h8000_0000;
    zv = longint'(signed'(t));
    xv = stcp_pkg::CORDIC_X0;
    yv = 0;
    for (int i = 0; i < 16; i++) begin
      if (zv >= 0) begin
        nx = xv - asr(yv, i);
        ny = yv + asr(xv, i);
        zv = zv - stcp_pkg::ATAN_TURNS[i];
      end else begin
        nx = xv + asr(yv, i);
        ny = yv - asr(xv, i);
        zv = zv + stcp_pkg::ATAN_TURNS[i];
      end
      xv = nx;
      yv = ny;
    end
    if (flip) begin
      xv = -xv;
      yv = -yv;
    end
    if (xv > 64'sd1073741824) xv = 64'sd1073741824;
    if (xv < -64'sd1073741824) xv = -64'sd1073741824;
    if (yv > 64'sd1073741824) yv = 64'sd1073741824;
    if (yv < -64'sd1073741824) yv = -64'sd1073741824;
    s = yv;
    c = xv;
  endfunction

  // magnitude product in Q1.30, truncated toward zero
  static function longint scale(longint v, longint f);
    logic [63:0] mv, mf, q;
    mv = (v < 0) ? -v : v;
    mf = (f < 0) ? -f : f;
    q  = ((mv >> 24) * mf + (((mv & 64'hFF_FFFF) * mf) >> 24)) >> 6;
    return ((v < 0) != (f < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function void note_point(logic [31:0] r, logic [15:0] az, logic [15:0] pol, logic lst);
    longint st, ct, sp, cp, rs;
    coord_t e;
    trig(az, st, ct);
    trig(pol, sp, cp);
    rs     = scale(longint'(r), sp);
    e.x    = 33'(scale(rs, ct));
    e.y    = 33'(scale(rs, st));
    e.z    = 33'(scale(longint'(r), cp));
    e.last = lst;
    pending_q.push_back(e);
  endfunction

  function void check_coord(logic [98:0] d, logic lst);
    coord_t e, a;
    a.x = d[32:0];
    a.y = d[65:33];
    a.z = d[98:66];
    a.last = lst;
    if (pending_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("unexpected result %h", a);
      return;
    end
    e = pending_q.pop_front();
    if (e !== a) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch: exp x=%0d y=%0d z=%0d l=%0b, got x=%0d y=%0d z=%0d l=%0b",
                 e.x, e.y, e.z, e.last, a.x, a.y, a.z, a.last);
    end
  endfunction
endclass

module tb;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [63:0]  s_axis_tdata_i = '0;  // radius, azimuth, polar
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;       // coord_x, coord_y, coord_z, pad
  logic         m_axis_tlast_o;

  point_scoreboard sb = new();
  int unsigned     cycle_cnt = 0;
  bit              calm = 1'b0;        // no idling on either side

  spherical_to_cartesian_point dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 200000) begin
      $display("[spherical_to_cartesian_point] ERROR");
      $finish;
    end
  end

  // sink: random stalls, checks on accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_coord(m_axis_tdata_o[98:0], m_axis_tlast_o);
      m_axis_tready_i <= calm || ($urandom_range(99) >= 28);
    end
  end

  task automatic send_point(logic [31:0] r, logic [15:0] az, logic [15:0] pol, logic lst);
    while (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pol, az, r};
    s_axis_tlast_i  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_point(r, az, pol, lst);
  endtask

  logic [15:0] dir_ang[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                               16'h2000, 16'h3FFF, 16'h4001, 16'hBFFF, 16'h0001};

  initial begin
    logic [31:0] r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: radius extremes and zero, quadrant boundaries on both angles
    for (int i = 0; i < 10; i++)
      send_point(32'hFFFF_FFFF, dir_ang[i], dir_ang[9 - i], i[0]);
    for (int i = 0; i < 6; i++)
      send_point(32'h0, dir_ang[i], dir_ang[i + 2], 1'b1);
    send_point(32'h0001_0000, 16'h0000, 16'h4000, 1'b0);
    send_point(32'h0000_0001, 16'hC000, 16'hC000, 1'b1);
    send_point(32'h8000_0000, 16'h8000, 16'h8000, 1'b0);
    // random points, with a calm stretch in the middle
    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 400 && n < 550);
      case ($urandom_range(3))
        0: r = $urandom_range(255);
        1: r = 32'hFFFF_FFFF - $urandom_range(255);
        default: r = $urandom;
      endcase
      send_point(r, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    end
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatch_cnt == 0 && sb.pending_q.size() == 0)
      $display("[spherical_to_cartesian_point] OK");
    else
      $display("[spherical_to_cartesian_point] ERROR");
    $finish;
  end
endmodule

[spherical_to_cartesian_point.f]
+incdir+sv
sv/stcp_pkg.sv
sv/stcp_delay.sv
sv/stcp_cordic.sv
sv/stcp_mul_q30.sv
sv/spherical_to_cartesian_point.sv
dv/tb.sv
